@@ design/cksa_pkg.sv @@
package cksa_pkg;

    // Operation codes carried on the request channel
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Control that travels with each transaction down the pipeline
    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg;   // sign of the result magnitude (multiply, divide)
        logic err;   // overflow or divide by zero already known
    } t_ctrl;

    // Register stages from the front stage to the multiplier result
    localparam int MUL_DEPTH = 3;

endpackage

@@ design/cksa_front.sv @@
module cksa_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  cksa_pkg::t_op          i_op,
    input  logic [DATA_WIDTH-1:0]  i_a,
    input  logic [DATA_WIDTH-1:0]  i_b,
    output cksa_pkg::t_ctrl        o_ctrl,
    output logic [DATA_WIDTH-1:0]  o_val,
    output logic [DATA_WIDTH-1:0]  o_ma,
    output logic [DATA_WIDTH-1:0]  o_mb
);
    import cksa_pkg::*;

    localparam int W = DATA_WIDTH;

    logic           na;
    logic           nb;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [W:0]     sa;
    logic [W:0]     sb;
    logic [W:0]     sum;
    logic           sum_ov;
    t_ctrl          n_ctrl;
    logic [W-1:0]   n_val;
    t_ctrl          r_ctrl;
    logic [W-1:0]   r_val;
    logic [W-1:0]   r_ma;
    logic [W-1:0]   r_mb;

    // Split operands into sign and magnitude
    always_comb begin
        na = i_a[W-1];
        nb = i_b[W-1];
        ma = na ? (~i_a + W'(1)) : i_a;
        mb = nb ? (~i_b + W'(1)) : i_b;
    end

    // Exact add or subtract one bit wider; overflow when the top two bits differ
    always_comb begin
        sa     = {i_a[W-1], i_a};
        sb     = {i_b[W-1], i_b};
        sum    = (i_op == OP_SUB) ? (sa - sb) : (sa + sb);
        sum_ov = sum[W] ^ sum[W-1];
    end

    // Build the control word for the transaction
    always_comb begin
        n_ctrl.valid = i_valid;
        n_ctrl.op    = i_op;
        n_ctrl.neg   = na ^ nb;
        n_ctrl.err   = 1'b0;
        n_val        = '0;
        case (i_op)
            OP_ADD, OP_SUB: begin
                n_ctrl.err = sum_ov;
                n_val      = sum[W-1:0];
            end
            OP_DIV: begin
                n_ctrl.err = (i_b == '0);
            end
            default: begin
                n_ctrl.err = 1'b0;
            end
        endcase
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_ma  <= ma;
            r_mb  <= mb;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_val  = r_val;
    assign o_ma   = r_ma;
    assign o_mb   = r_mb;

endmodule

@@ design/cksa_mul.sv @@
module cksa_mul #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic                   i_neg,
    input  logic [DATA_WIDTH-1:0]  i_ma,
    input  logic [DATA_WIDTH-1:0]  i_mb,
    output logic [DATA_WIDTH-1:0]  o_mag,
    output logic                   o_err
);
    localparam int W  = DATA_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int PW = 4 * H;

    logic [H-1:0]    a_lo;
    logic [H-1:0]    a_hi;
    logic [H-1:0]    b_lo;
    logic [H-1:0]    b_hi;
    logic [2*H-1:0]  r_pp0;
    logic [2*H-1:0]  r_pp1;
    logic [2*H-1:0]  r_pp2;
    logic [2*H-1:0]  r_pp3;
    logic            r_neg1;
    logic [PW-1:0]   n_prod;
    logic [PW-1:0]   r_prod;
    logic            r_neg2;
    logic [W-1:0]    lim;
    logic            n_err;
    logic [W-1:0]    r_mag;
    logic            r_err;

    // Split magnitudes into half words
    always_comb begin
        a_lo = i_ma[H-1:0];
        a_hi = H'(i_ma[W-1:H]);
        b_lo = i_mb[H-1:0];
        b_hi = H'(i_mb[W-1:H]);
    end

    // Stage one: four half-width partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp0  <= a_lo * b_lo;
            r_pp1  <= a_lo * b_hi;
            r_pp2  <= a_hi * b_lo;
            r_pp3  <= a_hi * b_hi;
            r_neg1 <= i_neg;
        end
    end

    // Stage two: align and sum the partial products
    always_comb begin
        n_prod = PW'(r_pp0)
               + ((PW'(r_pp1) + PW'(r_pp2)) << H)
               + (PW'(r_pp3) << (2 * H));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_neg2 <= r_neg1;
        end
    end

    // Stage three: range check against the signed limit of the result sign
    always_comb begin
        lim   = r_neg2 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        n_err = (|r_prod[PW-1:W]) || (r_prod[W-1:0] > lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= r_prod[W-1:0];
            r_err <= n_err;
        end
    end

    assign o_mag = r_mag;
    assign o_err = r_err;

endmodule

@@ design/cksa_div_step.sv @@
module cksa_div_step #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  cksa_pkg::t_ctrl        i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_val,
    input  logic [DATA_WIDTH-1:0]  i_rem,
    input  logic [DATA_WIDTH-1:0]  i_quo,
    input  logic [DATA_WIDTH-1:0]  i_dvs,
    output cksa_pkg::t_ctrl        o_ctrl,
    output logic [DATA_WIDTH-1:0]  o_val,
    output logic [DATA_WIDTH-1:0]  o_rem,
    output logic [DATA_WIDTH-1:0]  o_quo,
    output logic [DATA_WIDTH-1:0]  o_dvs
);
    import cksa_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          qbit;
    logic [W-1:0]  n_rem;
    t_ctrl         r_ctrl;
    logic [W-1:0]  r_val;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_dvs;

    // Restoring step: bring in the next dividend bit and try the subtract
    always_comb begin
        rem_sh = {i_rem, i_quo[W-1]};
        diff   = rem_sh - {1'b0, i_dvs};
        qbit   = ~diff[W];
        n_rem  = qbit ? diff[W-1:0] : rem_sh[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Advance remainder, shift quotient bit in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= i_val;
            r_rem <= n_rem;
            r_quo <= {i_quo[W-2:0], qbit};
            r_dvs <= i_dvs;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_val  = r_val;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_dvs  = r_dvs;

endmodule

@@ design/checked_signed_alu_core.sv @@
// Checked signed integer ALU: add, subtract, multiply, divide with overflow check.
//
// Request channel: i_valid with i_req_type, i_operand_a, i_operand_b. A
// transaction is taken at a rising edge with i_valid high and o_stall low.
// Response channel: o_valid with o_result_value and o_overflow_error, taken at
// a rising edge with o_valid high and i_stall low.
//
// Throughput is one transaction per cycle while the output is not stalled. Every
// transaction walks the same DATA_WIDTH + 2 register stages: a front stage
// (magnitudes, add/subtract), DATA_WIDTH restoring divider stages, one quotient
// bit each, and the output register. The multiplier runs in three stages beside
// the first divider stages.
//
// On error (out of range, divide by zero, minimum divided by minus one) the
// value is zero and o_overflow_error is set. Division truncates toward zero.
// Reset (synchronous, active low) empties the pipeline. While a waiting
// result is stalled the whole pipeline holds and o_stall is raised; items
// already inside are kept, nothing is dropped or repeated.
module checked_signed_alu_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_req_type,
    input  logic signed [DATA_WIDTH-1:0]  i_operand_a,
    input  logic signed [DATA_WIDTH-1:0]  i_operand_b,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DATA_WIDTH-1:0]  o_result_value,
    output logic                          o_overflow_error
);
    import cksa_pkg::*;

    localparam int W = DATA_WIDTH;

    logic          en;
    t_ctrl         st_ctrl [0:W];
    logic [W-1:0]  st_val  [0:W];
    logic [W-1:0]  st_rem  [0:W];
    logic [W-1:0]  st_quo  [0:W];
    logic [W-1:0]  st_dvs  [0:W];
    logic [W-1:0]  mul_mag;
    logic          mul_err;
    t_ctrl         fin_ctrl;
    logic [W-1:0]  mag;
    logic [W-1:0]  sval;
    logic          n_err;
    logic [W-1:0]  n_value;
    logic          r_out_valid;
    logic [W-1:0]  r_value;
    logic          r_err;

    // Pipeline advances unless the waiting result is stalled
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    cksa_front #(.DATA_WIDTH(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_op    (t_op'(i_req_type)),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_ctrl  (st_ctrl[0]),
        .o_val   (st_val[0]),
        .o_ma    (st_quo[0]),
        .o_mb    (st_dvs[0])
    );

    assign st_rem[0] = '0;

    cksa_mul #(.DATA_WIDTH(W)) u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_neg (st_ctrl[0].neg),
        .i_ma  (st_quo[0]),
        .i_mb  (st_dvs[0]),
        .o_mag (mul_mag),
        .o_err (mul_err)
    );

    // Divider stages; the multiplier result joins the lane where it is ready
    for (genvar k = 0; k < W; k++) begin : g_step
        t_ctrl         step_ctrl;
        logic [W-1:0]  step_val;

        always_comb begin
            step_ctrl = st_ctrl[k];
            step_val  = st_val[k];
            if ((k == MUL_DEPTH) && (st_ctrl[k].op == OP_MUL)) begin
                step_ctrl.err = mul_err;
                step_val      = mul_mag;
            end
        end

        cksa_div_step #(.DATA_WIDTH(W)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (step_ctrl),
            .i_val   (step_val),
            .i_rem   (st_rem[k]),
            .i_quo   (st_quo[k]),
            .i_dvs   (st_dvs[k]),
            .o_ctrl  (st_ctrl[k+1]),
            .o_val   (st_val[k+1]),
            .o_rem   (st_rem[k+1]),
            .o_quo   (st_quo[k+1]),
            .o_dvs   (st_dvs[k+1])
        );
    end

    // Final stage: pick the result, apply sign, zero it on error
    always_comb begin
        fin_ctrl = st_ctrl[W];
        mag      = st_val[W];
        n_err    = fin_ctrl.err;
        case (fin_ctrl.op)
            OP_ADD, OP_SUB: begin
                mag   = st_val[W];
                n_err = fin_ctrl.err;
            end
            OP_MUL: begin
                mag   = st_val[W];
                n_err = fin_ctrl.err;
            end
            OP_DIV: begin
                mag   = st_quo[W];
                n_err = fin_ctrl.err || (!fin_ctrl.neg && st_quo[W][W-1]);
            end
            default: begin
                mag   = st_val[W];
                n_err = fin_ctrl.err;
            end
        endcase
        if ((fin_ctrl.op == OP_MUL || fin_ctrl.op == OP_DIV) && fin_ctrl.neg) begin
            sval = ~mag + W'(1);
        end else begin
            sval = mag;
        end
        n_value = n_err ? '0 : sval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_value <= n_value;
            r_err   <= n_err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_value   = r_value;
    assign o_overflow_error = r_err;

`ifndef SYNTHESIS
    a_last_stage_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctrl[W].valid && en |=> o_valid)
        else $error("transaction in last divider stage did not reach output");

    a_error_zeroes_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow_error |-> o_result_value == '0)
        else $error("error result carries a non-zero value");

    a_div_zero_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctrl[0].valid && st_ctrl[0].op == OP_DIV && st_dvs[0] == '0
        |-> st_ctrl[0].err)
        else $error("divide by zero not flagged at front stage");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(st_ctrl[W]) && $stable(st_quo[W]))
        else $error("pipeline moved while output stalled");
`endif

endmodule

@@ test/checked_signed_alu_core_tb.sv @@
module checked_signed_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cksa_pkg::*;

    localparam int W          = 32;
    localparam int LATENCY    = W + 2;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_RANDOM = 850;

    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] S_ONE = 1;
    localparam logic signed [W-1:0] S_NEG = -1;

    // One expected response transaction
    typedef struct packed {
        logic signed [W-1:0] value;
        logic                err;
    } t_alu_result;

    // One directed row; known marks an expectation typed in by hand
    typedef struct packed {
        t_op                 op;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        bit                  known;
        logic signed [W-1:0] val;
        logic                err;
    } t_row;

    localparam int NUM_DIR = 24;
    localparam t_row DIR_ROWS [NUM_DIR] = '{
        '{OP_ADD, S_MAX,   S_ONE,   1'b1, '0,      1'b1},
        '{OP_ADD, S_MIN,   S_NEG,   1'b1, '0,      1'b1},
        '{OP_ADD, S_MAX,   S_MIN,   1'b1, S_NEG,   1'b0},
        '{OP_ADD, S_MIN,   S_MIN,   1'b1, '0,      1'b1},
        '{OP_SUB, S_MIN,   S_ONE,   1'b1, '0,      1'b1},
        '{OP_SUB, '0,      S_MIN,   1'b1, '0,      1'b1},
        '{OP_SUB, S_NEG,   S_MIN,   1'b1, S_MAX,   1'b0},
        '{OP_SUB, S_MAX,   S_NEG,   1'b1, '0,      1'b1},
        '{OP_MUL, S_MAX,   S_MAX,   1'b1, '0,      1'b1},
        '{OP_MUL, S_MIN,   S_ONE,   1'b1, S_MIN,   1'b0},
        '{OP_MUL, S_MIN,   S_NEG,   1'b1, '0,      1'b1},
        '{OP_MUL, '0,      S_MIN,   1'b1, '0,      1'b0},
        '{OP_MUL, 65536,   32768,   1'b1, '0,      1'b1},
        '{OP_MUL, -65536,  32768,   1'b1, S_MIN,   1'b0},
        '{OP_MUL, 46341,   46341,   1'b0, '0,      1'b0},
        '{OP_MUL, -46340,  46341,   1'b0, '0,      1'b0},
        '{OP_DIV, 1234,    '0,      1'b1, '0,      1'b1},
        '{OP_DIV, S_MIN,   S_NEG,   1'b1, '0,      1'b1},
        '{OP_DIV, S_MIN,   S_ONE,   1'b1, S_MIN,   1'b0},
        '{OP_DIV, 7,       -2,      1'b1, -3,      1'b0},
        '{OP_DIV, -7,      2,       1'b1, -3,      1'b0},
        '{OP_DIV, S_MIN,   S_MIN,   1'b1, S_ONE,   1'b0},
        '{OP_DIV, S_MAX,   S_MIN,   1'b1, '0,      1'b0},
        '{OP_ADD, -12345,  678,     1'b0, '0,      1'b0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_req_type = '0;
    logic signed [W-1:0] i_operand_a = '0;
    logic signed [W-1:0] i_operand_b = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic signed [W-1:0] o_result_value;
    logic                o_overflow_error;

    t_alu_result pending_results [$];
    bit          calm = 1'b0;
    int          fail_count = 0;
    int          results_seen = 0;
    int          flagged_seen = 0;
    int          sent_count = 0;
    int          idle_cycles = 0;

    checked_signed_alu_core #(.DATA_WIDTH(W)) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_value   (o_result_value),
        .o_overflow_error (o_overflow_error)
    );

    always #1 i_clk = ~i_clk;

    // Exact result at double width, then range check against the signed word
    function automatic t_alu_result compute_checked_result(
        input t_op op, input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        longint      wa;
        longint      wb;
        longint      wr;
        t_alu_result res;
        wa = longint'(a);
        wb = longint'(b);
        wr = 0;
        res.err = 1'b0;
        case (op)
            OP_ADD: wr = wa + wb;
            OP_SUB: wr = wa - wb;
            OP_MUL: wr = wa * wb;
            OP_DIV: begin
                if (wb == 0) res.err = 1'b1;
                else wr = wa / wb;
            end
            default: res.err = 1'b1;
        endcase
        if (!res.err && (wr > longint'(S_MAX) || wr < longint'(S_MIN))) res.err = 1'b1;
        res.value = res.err ? '0 : wr[W-1:0];
        return res;
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Operand mix: full-width noise, extremes, small values, powers of two,
    // and values near the square root of the range to probe multiply overflow
    function automatic logic signed [W-1:0] pick_operand();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4: begin
                case ($urandom_range(0, 5))
                    0: v = S_MIN;
                    1: v = S_MAX;
                    2: v = '0;
                    3: v = S_ONE;
                    4: v = S_NEG;
                    default: v = $urandom_range(0, 1) ? S_MIN + 1 : S_MAX - 1;
                endcase
            end
            5: v = $signed($urandom_range(0, 200)) - 100;
            6: v = (S_ONE <<< $urandom_range(0, W-1)) + ($signed($urandom_range(0, 2)) - 1);
            7: v = 46341 + ($signed($urandom_range(0, 4)) - 2);
            8: v = {{(W-16){$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: v = '0;
        endcase
        if (($urandom_range(0, 3) == 0) && v != S_MIN) v = -v;
        return v;
    endfunction

    // Present one request, hold it until taken, record its expectation
    task automatic send_request(input t_op op, input logic signed [W-1:0] a,
                                input logic signed [W-1:0] b, input t_alu_result want);
        int gap;
        i_valid     <= 1'b1;
        i_req_type  <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver back-pressure
    initial begin
        int len;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                len = pick_gap() + 1;
                i_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each taken response with the oldest expectation
    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected response: result_value %0d overflow_error %0b",
                       o_result_value, o_overflow_error);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_overflow_error === 1'b1) flagged_seen++;
                if (o_result_value !== want.value) begin
                    $error("result_value mismatch: expected %0d, actual %0d",
                           want.value, o_result_value);
                    fail_count++;
                end
                if (o_overflow_error !== want.err) begin
                    $error("overflow_error mismatch: expected %0b, actual %0b",
                           want.err, o_overflow_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: reset, directed table, then random traffic
    initial begin
        t_alu_result want;
        t_op         op;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            if (DIR_ROWS[i].known) begin
                want.value = DIR_ROWS[i].val;
                want.err   = DIR_ROWS[i].err;
            end else begin
                want = compute_checked_result(DIR_ROWS[i].op, DIR_ROWS[i].a, DIR_ROWS[i].b);
            end
            send_request(DIR_ROWS[i].op, DIR_ROWS[i].a, DIR_ROWS[i].b, want);
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            // every fourth block of a hundred runs at full rate on both sides
            calm = ((i / 100) % 4) == 3;
            op = t_op'($urandom_range(0, 3));
            begin
                logic signed [W-1:0] a;
                logic signed [W-1:0] b;
                a = pick_operand();
                b = (op == OP_DIV && $urandom_range(0, 15) == 0) ? '0 : pick_operand();
                send_request(op, a, b, compute_checked_result(op, a, b));
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Drain, then watch for stray responses
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed, %0d random) across all four operations.",
                 sent_count, NUM_DIR, NUM_RANDOM);
        $display("Checked %0d responses, %0d of them flagged as overflow or divide by zero.",
                 results_seen, flagged_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ checked_signed_alu_core.f @@
design/cksa_pkg.sv
design/cksa_front.sv
design/cksa_mul.sv
design/cksa_div_step.sv
design/checked_signed_alu_core.sv
test/checked_signed_alu_core_tb.sv
